// ===== hdl/ackw_pkg.sv =====
`timescale 1ns / 1ps

package ackw_pkg;

    localparam int SEQ_W        = 64;
    localparam int WORD_W       = 64;
    localparam int WINDOW_BITS  = 128;
    localparam int WIN_IDX_W    = $clog2(WINDOW_BITS);
    localparam int TICK_W       = 32;
    localparam int COUNT_W      = 8;
    localparam int CFG_DATA_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX          = '1;
    localparam logic [COUNT_W-1:0] ACK_EVERY_RESET    = 8'd8;
    localparam logic [TICK_W-1:0]  ACK_INTERVAL_RESET = 32'd10000;

    typedef enum logic
    {
        FUNC_DATA = 1'b0,
        FUNC_ACK  = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        CFG_LINK_ENABLE  = 2'd0,
        CFG_ACK_EVERY    = 2'd1,
        CFG_ACK_INTERVAL = 2'd2
    } cfg_idx_t;

    typedef struct packed
    {
        func_t              func;
        logic [SEQ_W-1:0]   seq_number;
        logic               force_ack;
        logic [TICK_W-1:0]  now_ticks;
    } in_item_t;

    typedef struct packed
    {
        logic               ack_sent;
        logic [SEQ_W-1:0]   ack_largest;
        logic [WORD_W-1:0]  ack_mask_low;
        logic [WORD_W-1:0]  ack_mask_high;
    } out_item_t;

    typedef struct packed
    {
        logic               link_enable;
        logic [COUNT_W-1:0] ack_every_packets;
        logic [TICK_W-1:0]  ack_interval_ticks;
    } cfg_t;

    typedef struct packed
    {
        logic                   started;
        logic [SEQ_W-1:0]       largest;
        logic [WINDOW_BITS-1:0] bitmap;
    } win_state_t;

endpackage

// ===== hdl/receive_ack_window_top.sv =====
`timescale 1ns / 1ps

// Receive ack window tracker.
// Input channel (in_valid / in_stall / in_data) carries either a data item
// (func = data, seq_number used) or an ack request (func = ack, force_ack and
// now_ticks used). Every ack request gives exactly one result on the output
// channel (out_valid / out_stall / out_data); data items give none.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data, cfg_ready is
// always high; index 0 link_enable, 1 ack_every_packets, 2 ack_interval_ticks.
// Write configuration only while no item is in flight.
// An item is taken into the input register and processed from there; a result
// is registered and appears on out_data. One item per cycle sustained unless an
// ack request waits on a stalled result: the bitmap shift, sequence compare and
// pacing check fit between the input register and the result register.
// A stalled result holds out_data; the input register keeps taking data items
// behind it, and an ack request waits there until the result is taken, with
// in_stall high while it waits. Reset clears the window, pacing state and both
// valid flags; configuration returns to disabled, 8 packets, 10000 ticks.
module receive_ack_window_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ackw_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ackw_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  ackw_pkg::cfg_idx_t   cfg_index,
    input  logic [ackw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ackw_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       in_valid_reg, in_valid_next;
    in_item_t   in_reg, in_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;

    logic       advance;
    logic       proc;
    logic       take_pkt;
    logic       ack_req;
    logic       send;
    win_state_t win;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LINK_ENABLE:  cfg_next.link_enable        = cfg_data[0];
                CFG_ACK_EVERY:    cfg_next.ack_every_packets  = cfg_data[COUNT_W-1:0];
                CFG_ACK_INTERVAL: cfg_next.ack_interval_ticks = cfg_data[TICK_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // data items never need the output slot
    assign advance  = (in_reg.func == FUNC_DATA) || !out_valid_reg || !out_stall;
    assign proc     = in_valid_reg && advance;
    assign take_pkt = proc && (in_reg.func == FUNC_DATA) && cfg_reg.link_enable;
    assign ack_req  = proc && (in_reg.func == FUNC_ACK);
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_next       = in_reg;
        if (in_valid && !in_stall)
        begin
            in_valid_next = 1'b1;
            in_next       = in_data;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (ack_req)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (send)
            begin
                out_next.ack_sent      = 1'b1;
                out_next.ack_largest   = win.largest;
                out_next.ack_mask_low  = win.bitmap[WORD_W-1:0];
                out_next.ack_mask_high = win.bitmap[WINDOW_BITS-1:WORD_W];
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_enable        <= 1'b0;
            cfg_reg.ack_every_packets  <= ACK_EVERY_RESET;
            cfg_reg.ack_interval_ticks <= ACK_INTERVAL_RESET;
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    ackw_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take_pkt (take_pkt),
        .seq      (in_reg.seq_number),
        .win      (win)
    );

    ackw_pacer u_pacer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .started   (win.started),
        .take_pkt  (take_pkt),
        .ack_req   (ack_req),
        .force_ack (in_reg.force_ack),
        .now_ticks (in_reg.now_ticks),
        .send      (send)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_sent_has_largest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.ack_sent |-> out_reg.ack_mask_low[0])
        else $error("sent ack without largest marked");

    a_unsent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.ack_sent |->
            out_reg.ack_largest == '0 && out_reg.ack_mask_low == '0
            && out_reg.ack_mask_high == '0)
        else $error("unsent ack carries data");

    a_ack_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_reg.func == FUNC_ACK && out_valid_reg && out_stall |=> in_valid_reg)
        else $error("ack request dropped while output stalled");

endmodule

// ===== hdl/ackw_window.sv =====
`timescale 1ns / 1ps

module ackw_window
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take_pkt,
    input  logic [ackw_pkg::SEQ_W-1:0] seq,
    output ackw_pkg::win_state_t win
);
    import ackw_pkg::*;

    logic                   started_reg, started_next;
    logic [SEQ_W-1:0]       largest_reg, largest_next;
    logic [WINDOW_BITS-1:0] bitmap_reg, bitmap_next;

    logic [SEQ_W-1:0]       ahead;
    logic [SEQ_W-1:0]       behind;
    logic                   newer;

    assign ahead  = seq - largest_reg;
    assign behind = largest_reg - seq;
    assign newer  = seq > largest_reg;

    always_comb
    begin
        started_next = started_reg;
        largest_next = largest_reg;
        bitmap_next  = bitmap_reg;
        if (take_pkt)
        begin
            started_next = 1'b1;
            if (!started_reg)
            begin
                largest_next = seq;
                bitmap_next  = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
            end
            else if (newer)
            begin
                largest_next = seq;
                // gap of a full window or more drops every old bit
                if (|ahead[SEQ_W-1:WIN_IDX_W])
                    bitmap_next = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
                else
                    bitmap_next = (bitmap_reg << ahead[WIN_IDX_W-1:0])
                                  | {{(WINDOW_BITS-1){1'b0}}, 1'b1};
            end
            else if (!(|behind[SEQ_W-1:WIN_IDX_W]))
            begin
                bitmap_next = bitmap_reg
                              | ({{(WINDOW_BITS-1){1'b0}}, 1'b1} << behind[WIN_IDX_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            largest_reg <= '0;
            bitmap_reg  <= '0;
        end
        else
        begin
            started_reg <= started_next;
            largest_reg <= largest_next;
            bitmap_reg  <= bitmap_next;
        end
    end

    assign win.started = started_reg;
    assign win.largest = largest_reg;
    assign win.bitmap  = bitmap_reg;

    a_empty_until_started: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> bitmap_reg == '0)
        else $error("bitmap set before first packet");

    a_largest_marked: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> bitmap_reg[0])
        else $error("largest sequence not marked in bitmap");

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        take_pkt |=> started_reg)
        else $error("packet did not start the window");

endmodule

// ===== hdl/ackw_pacer.sv =====
`timescale 1ns / 1ps

module ackw_pacer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ackw_pkg::cfg_t              cfg,
    input  logic                        started,
    input  logic                        take_pkt,
    input  logic                        ack_req,
    input  logic                        force_ack,
    input  logic [ackw_pkg::TICK_W-1:0] now_ticks,
    output logic                        send
);
    import ackw_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               pending_reg, pending_next;
    logic               acked_reg, acked_next;
    logic [TICK_W-1:0]  last_time_reg, last_time_next;

    logic [TICK_W-1:0]  elapsed;
    logic               allowed;

    // modulo 2^32 difference handles tick wrap
    assign elapsed = now_ticks - last_time_reg;
    assign allowed = force_ack || (count_reg >= cfg.ack_every_packets)
                     || !acked_reg || (elapsed >= cfg.ack_interval_ticks);
    assign send    = ack_req && cfg.link_enable && started && pending_reg && allowed;

    always_comb
    begin
        count_next     = count_reg;
        pending_next   = pending_reg;
        acked_next     = acked_reg;
        last_time_next = last_time_reg;
        if (take_pkt)
        begin
            if (count_reg != COUNT_MAX)
                count_next = count_reg + 1'b1;
            pending_next = 1'b1;
        end
        else if (send)
        begin
            count_next     = '0;
            pending_next   = 1'b0;
            acked_next     = 1'b1;
            last_time_next = now_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            acked_reg     <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            acked_reg     <= acked_next;
            last_time_reg <= last_time_next;
        end
    end

    a_send_clears: assert property (@(posedge clk) disable iff (!rst_n)
        send |=> !pending_reg && count_reg == '0 && acked_reg)
        else $error("ack did not clear pacing state");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> count_reg == '0)
        else $error("packets counted without pending ack");

    a_pkt_pends: assert property (@(posedge clk) disable iff (!rst_n)
        take_pkt |=> pending_reg && count_reg != '0)
        else $error("packet did not mark ack pending");

endmodule

// ===== bench/receive_ack_window_top_tb.sv =====
`timescale 1ns / 1ps

module receive_ack_window_top_tb;

    import ackw_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int REPORT_MAX   = 10;

    class ack_window_scoreboard;
        // register copies
        logic                   link_enable;
        logic [COUNT_W-1:0]     ack_every;
        logic [TICK_W-1:0]      ack_interval;
        // tracker state
        logic                   started;
        logic [SEQ_W-1:0]       largest;
        logic [WINDOW_BITS-1:0] bitmap;
        logic [COUNT_W-1:0]     since_ack;
        logic                   ack_pending;
        logic                   acked_before;
        logic [TICK_W-1:0]      last_ack_time;

        out_item_t expected_acks[$];
        int bad_results;
        int data_items;
        int ack_requests;
        int acks_sent;
        int reg_writes;

        function new();
            link_enable   = 1'b0;
            ack_every     = ACK_EVERY_RESET;
            ack_interval  = ACK_INTERVAL_RESET;
            started       = 1'b0;
            largest       = '0;
            bitmap        = '0;
            since_ack     = '0;
            ack_pending   = 1'b0;
            acked_before  = 1'b0;
            last_ack_time = '0;
            bad_results   = 0;
            data_items    = 0;
            ack_requests  = 0;
            acks_sent     = 0;
            reg_writes    = 0;
        endfunction

        function void note_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            reg_writes++;
            case (idx)
                CFG_LINK_ENABLE:  link_enable  = value[0];
                CFG_ACK_EVERY:    ack_every    = value[COUNT_W-1:0];
                CFG_ACK_INTERVAL: ack_interval = value[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(in_item_t item);
            out_item_t        answer;
            logic [SEQ_W-1:0] gap;
            logic [TICK_W-1:0] elapsed;
            bit               allow;
            if (item.func == FUNC_DATA)
            begin
                data_items++;
                if (!link_enable)
                    return;
                if (!started)
                begin
                    started = 1'b1;
                    largest = item.seq_number;
                    bitmap  = WINDOW_BITS'(1);
                end
                else if (item.seq_number > largest)
                begin
                    gap = item.seq_number - largest;
                    if (gap >= WINDOW_BITS)
                        bitmap = '0;
                    else
                        bitmap = bitmap << gap[WIN_IDX_W-1:0];
                    largest   = item.seq_number;
                    bitmap[0] = 1'b1;
                end
                else
                begin
                    // duplicate or older: mark its slot if still inside the window
                    gap = largest - item.seq_number;
                    if (gap < WINDOW_BITS)
                        bitmap[gap[WIN_IDX_W-1:0]] = 1'b1;
                end
                if (since_ack != COUNT_MAX)
                    since_ack++;
                ack_pending = 1'b1;
                return;
            end
            ack_requests++;
            answer  = '0;
            elapsed = item.now_ticks - last_ack_time;
            allow   = item.force_ack || (since_ack >= ack_every) || !acked_before ||
                      (elapsed >= ack_interval);
            if (link_enable && started && ack_pending && allow)
            begin
                answer.ack_sent      = 1'b1;
                answer.ack_largest   = largest;
                answer.ack_mask_low  = bitmap[WORD_W-1:0];
                answer.ack_mask_high = bitmap[WINDOW_BITS-1:WORD_W];
                ack_pending   = 1'b0;
                since_ack     = '0;
                acked_before  = 1'b1;
                last_ack_time = item.now_ticks;
                acks_sent++;
            end
            expected_acks.push_back(answer);
        endfunction

        function void check_ack(out_item_t got);
            out_item_t want;
            bit        bad;
            if (expected_acks.size() == 0)
            begin
                bad_results++;
                if (bad_results <= REPORT_MAX)
                    $display("unexpected result: sent=%0b largest=%h low=%h high=%h",
                             got.ack_sent, got.ack_largest, got.ack_mask_low,
                             got.ack_mask_high);
                return;
            end
            want = expected_acks.pop_front();
            bad  = (got.ack_sent !== want.ack_sent) ||
                   (got.ack_largest !== want.ack_largest) ||
                   (got.ack_mask_low !== want.ack_mask_low) ||
                   (got.ack_mask_high !== want.ack_mask_high);
            if (bad)
            begin
                bad_results++;
                if (bad_results <= REPORT_MAX)
                begin
                    $display("ack mismatch: exp sent=%0b largest=%h low=%h high=%h",
                             want.ack_sent, want.ack_largest, want.ack_mask_low,
                             want.ack_mask_high);
                    $display("              got sent=%0b largest=%h low=%h high=%h",
                             got.ack_sent, got.ack_largest, got.ack_mask_low,
                             got.ack_mask_high);
                end
            end
        endfunction

        function int pending();
            return expected_acks.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ack_window_scoreboard ack_board = new();

    int               quiet_cycles = 0;
    int               in_idle_pct  = 28;
    int               out_stall_pct = 28;
    int               failures;
    logic [SEQ_W-1:0] seq_cursor;
    logic [TICK_W-1:0] tick_cursor;

    receive_ack_window_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // observe every transfer at the rising edge; results are checked before
    // the input of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                ack_board.check_ack(out_data);
            if (in_valid && !in_stall)
                ack_board.note_input(in_data);
            if (cfg_valid && cfg_ready)
                ack_board.note_register(cfg_index, cfg_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("receive_ack_window_top regression: fail");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(99) < out_stall_pct);
        end
    end

    // all drive tasks start and end just after a falling edge
    task automatic push_item(input in_item_t item);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_data(input logic [SEQ_W-1:0] seq);
        in_item_t item;
        item.func       = FUNC_DATA;
        item.seq_number = seq;
        item.force_ack  = 1'($urandom_range(1));
        item.now_ticks  = $urandom;
        push_item(item);
    endtask

    task automatic send_ack(input logic force_it, input logic [TICK_W-1:0] now);
        in_item_t item;
        item.func       = FUNC_ACK;
        item.seq_number = {$urandom, $urandom};
        item.force_ack  = force_it;
        item.now_ticks  = now;
        push_item(item);
    endtask

    task automatic wait_for_acks();
        in_valid = 1'b0;
        while (ack_board.pending() != 0)
            @(negedge clk);
        // data transfers still in the pipe produce no result
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic en, input logic [COUNT_W-1:0] every,
                             input logic [TICK_W-1:0] interval);
        wait_for_acks();
        write_reg(CFG_LINK_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_ACK_EVERY, CFG_DATA_W'(every));
        write_reg(CFG_ACK_INTERVAL, interval);
    endtask

    // mostly in-order traffic around the cursor, with reorder, duplicates,
    // gaps past the window and some random sequence noise
    task automatic run_phase(input int n_items, input int ack_pct, input int tick_step);
        in_item_t item;
        int       pick;
        repeat (n_items)
        begin
            item.seq_number = {$urandom, $urandom};
            item.force_ack  = 1'($urandom_range(1));
            item.now_ticks  = $urandom;
            if ($urandom_range(99) < ack_pct)
            begin
                item.func      = FUNC_ACK;
                item.force_ack = ($urandom_range(3) == 0);
                if ($urandom_range(49) == 0)
                    tick_cursor = $urandom;
                else
                    tick_cursor += $urandom_range(tick_step);
                item.now_ticks = tick_cursor;
            end
            else
            begin
                item.func = FUNC_DATA;
                pick      = $urandom_range(99);
                if (pick < 50)
                    item.seq_number = seq_cursor + $urandom_range(1, 3);
                else if (pick < 75)
                    item.seq_number = seq_cursor - $urandom_range(140);
                else if (pick < 90)
                    item.seq_number = seq_cursor + $urandom_range(4, 200);
                // else keep the random value as noise
                if (item.seq_number > seq_cursor)
                    seq_cursor = item.seq_number;
            end
            push_item(item);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LINK_ENABLE;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // link still disabled out of reset
        send_data(64'h5);
        send_ack(1'b1, 32'h0);
        wait_for_acks();
        write_reg(CFG_LINK_ENABLE, CFG_DATA_W'(1));

        send_ack(1'b1, 32'd200);            // nothing received yet
        send_data(64'h1000);                // first packet opens the window
        send_ack(1'b0, 32'd300);            // first ack is never paced
        send_ack(1'b1, 32'd310);            // nothing pending
        send_data(64'h1001);
        send_data(64'h1040);
        send_data(64'h1000);                // offset 64, upper mask word
        send_data(64'h0FC1);                // offset 127
        send_data(64'h0FC0);                // offset 128, outside
        send_data(64'h1040);                // duplicate
        send_ack(1'b0, 32'd400);            // paced out
        send_data(64'h1080);                // gap of one word
        send_data(64'h10E4);                // gap 100
        send_ack(1'b0, 32'd500);            // packet count reached
        send_data(64'h1164);                // gap 128 clears the window
        send_data(64'h0);
        send_ack(1'b0, 32'hFFFF_FFFF);      // interval elapsed
        send_data(64'h1163);
        send_ack(1'b0, 32'h0000_2000);      // tick wrap, short of interval
        send_ack(1'b0, 32'h0000_270F);      // tick wrap, exactly the interval

        seq_cursor  = 64'h1164;
        tick_cursor = 32'h0000_3000;

        configure(1'b1, 8'd8, 32'd10000);
        run_phase(300, 20, 3000);

        // long stretch with neither side idling
        in_idle_pct   = 0;
        out_stall_pct = 0;
        configure(1'b1, 8'd1, 32'd0);
        run_phase(400, 30, 50);
        in_idle_pct   = 28;
        out_stall_pct = 28;

        // rare acks so the packet count saturates
        configure(1'b1, 8'd255, 32'hFFFF_FFFF);
        run_phase(350, 2, 100000);

        // disabled: state must survive into the next phase
        configure(1'b0, 8'd2, 32'd100);
        run_phase(100, 30, 100);

        configure(1'b1, 8'd3, 32'd500);
        run_phase(300, 25, 300);

        configure(1'b1, 8'd0, $urandom);
        run_phase(200, 30, 1000);

        configure(1'b1, 8'($urandom_range(1, 255)), 32'($urandom_range(20000)));
        run_phase(250, 25, 2000);

        // top of the sequence space
        configure(1'b1, 8'd8, 32'd10000);
        send_data(64'hFFFF_FFFF_FFFF_FFFF);
        send_data(64'hFFFF_FFFF_FFFF_FF80);
        send_ack(1'b1, $urandom);

        wait_for_acks();
        failures = ack_board.bad_results + ack_board.pending();
        $display("covered %0d data packets and %0d ack requests, %0d acks sent",
                 ack_board.data_items, ack_board.ack_requests, ack_board.acks_sent);
        $display("%0d register writes across 8 settings, %0d bad results",
                 ack_board.reg_writes, ack_board.bad_results);
        if (failures == 0)
            $display("receive_ack_window_top regression: pass");
        else
            $display("receive_ack_window_top regression: fail");
        $finish;
    end

endmodule
